### design/cau_pkg.sv
package cau_pkg;

  localparam int FUNC_W = 4;
  localparam int STAT_W = 2;

  localparam logic [FUNC_W-1:0] FN_ADD  = 4'd0;
  localparam logic [FUNC_W-1:0] FN_SUB  = 4'd1;
  localparam logic [FUNC_W-1:0] FN_MUL  = 4'd2;
  localparam logic [FUNC_W-1:0] FN_DIV  = 4'd3;
  localparam logic [FUNC_W-1:0] FN_NEG  = 4'd4;
  localparam logic [FUNC_W-1:0] FN_NORM = 4'd5;
  localparam logic [FUNC_W-1:0] FN_CONJ = 4'd6;
  localparam logic [FUNC_W-1:0] FN_SCAL = 4'd7;
  localparam logic [FUNC_W-1:0] FN_RDIV = 4'd8;

  localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
  localparam logic [STAT_W-1:0] ST_SAT = 2'd1;
  localparam logic [STAT_W-1:0] ST_DZ  = 2'd2;

endpackage

### design/complex_arithmetic_unit.sv
// Pipelined complex ALU on signed fixed-point operands. One transfer can enter every cycle
// while out_stall does not hold a result; the depth of the pipeline is mostly set by the
// restoring divider, which resolves one quotient bit per stage for
// DATA_WIDTH + 1 stages, with one stage each for the multipliers, the product sums, the
// divider setup and the output register. When out_stall holds a result, the whole pipeline
// freezes and in_stall is raised.
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cau_pkg::FUNC_W-1:0]    func,
  input  logic signed [DATA_WIDTH-1:0]  a_re,
  input  logic signed [DATA_WIDTH-1:0]  a_im,
  input  logic signed [DATA_WIDTH-1:0]  b_re,
  input  logic signed [DATA_WIDTH-1:0]  b_im,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [DATA_WIDTH-1:0]  r_re,
  output logic signed [DATA_WIDTH-1:0]  r_im,
  output logic                          equal,
  output logic [cau_pkg::STAT_W-1:0]    status
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W + 2;
  localparam int MW = 2 * W + 1;
  localparam int RW = MW + F + W + 2;
  localparam int QW = W + 1;
  localparam int NS = W + 3;
  localparam logic [PW-1:0] MAXM = PW'((64'd1 << (W - 1)) - 64'd1);

  typedef struct packed {
    logic         div;
    logic         dz;
    logic         neg_re;
    logic         neg_im;
    logic         ovf_re;
    logic         ovf_im;
    logic         eq;
    logic         sat;
    logic [W-1:0] re;
    logic [W-1:0] im;
  } side_t;

  function automatic logic [W:0] clamp_sm(input logic neg, input logic [PW-1:0] mag);
    logic [W:0] r;
    if (!neg) begin
      if (mag > MAXM) r = {1'b1, 1'b0, {(W-1){1'b1}}};
      else r = {1'b0, mag[W-1:0]};
    end else begin
      if (mag > MAXM + PW'(1)) r = {1'b1, 1'b1, {(W-1){1'b0}}};
      else r = {1'b0, W'(~mag[W-1:0] + W'(1))};
    end
    return r;
  endfunction

  function automatic logic [W:0] clamp_v(input logic signed [W:0] v);
    logic [W:0] r;
    if (v[W] != v[W-1]) r = {1'b1, v[W], {(W-1){~v[W]}}};
    else r = {1'b0, v[W-1:0]};
    return r;
  endfunction

  function automatic logic [W:0] from_prod(input logic signed [PW-1:0] v);
    logic [PW-1:0] mag;
    mag = v[PW-1] ? PW'(-v) : PW'(v);
    return clamp_sm(v[PW-1], mag >> F);
  endfunction

  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage A: products and simple sums.
  logic                        a_vld;
  logic [cau_pkg::FUNC_W-1:0]  a_func;
  logic                        a_eq;
  logic signed [2*W-1:0]       p_rr, p_ii, p_ir, p_ri, p_bb_r, p_bb_i, p_aa_r, p_aa_i;
  logic signed [W:0]           a_s_re, a_s_im;
  logic [W:0]                  a_m_re, a_m_im, a_m_br;
  logic                        a_neg_re, a_neg_im, a_brz;

  logic signed [W:0] ar_x, ai_x, br_x, bi_x, s_re_next, s_im_next;
  assign ar_x = {a_re[W-1], a_re};
  assign ai_x = {a_im[W-1], a_im};
  assign br_x = {b_re[W-1], b_re};
  assign bi_x = {b_im[W-1], b_im};

  always_comb begin
    case (func)
      cau_pkg::FN_ADD: begin
        s_re_next = ar_x + br_x;
        s_im_next = ai_x + bi_x;
      end
      cau_pkg::FN_SUB: begin
        s_re_next = ar_x - br_x;
        s_im_next = ai_x - bi_x;
      end
      cau_pkg::FN_NEG: begin
        s_re_next = -ar_x;
        s_im_next = -ai_x;
      end
      cau_pkg::FN_CONJ: begin
        s_re_next = ar_x;
        s_im_next = -ai_x;
      end
      default: begin
        s_re_next = '0;
        s_im_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
    end
    if (en) begin
      a_func   <= func;
      a_eq     <= (a_re == b_re) && (a_im == b_im);
      p_rr     <= a_re * b_re;
      p_ii     <= a_im * b_im;
      p_ir     <= a_im * b_re;
      p_ri     <= a_re * b_im;
      p_bb_r   <= b_re * b_re;
      p_bb_i   <= b_im * b_im;
      p_aa_r   <= a_re * a_re;
      p_aa_i   <= a_im * a_im;
      a_s_re   <= s_re_next;
      a_s_im   <= s_im_next;
      a_m_re   <= ar_x[W] ? (W+1)'(-ar_x) : (W+1)'(ar_x);
      a_m_im   <= ai_x[W] ? (W+1)'(-ai_x) : (W+1)'(ai_x);
      a_m_br   <= br_x[W] ? (W+1)'(-br_x) : (W+1)'(br_x);
      a_neg_re <= a_re[W-1] ^ b_re[W-1];
      a_neg_im <= a_im[W-1] ^ b_re[W-1];
      a_brz    <= (b_re == '0);
    end
  end

  // Stage B: product sums, saturation of the non-dividing operations, divider operands.
  logic signed [PW-1:0] x_rr, x_ii, x_ir, x_ri, x_sum_re, x_sum_im, x_dn_re, x_dn_im;
  logic [PW-1:0]        x_c;
  side_t                b_side;
  logic [MW-1:0]        b_n_re, b_n_im, b_c;
  logic [W:0]           cr_re, cr_im, cv_re, cv_im;

  assign x_rr = PW'(p_rr);
  assign x_ii = PW'(p_ii);
  assign x_ir = PW'(p_ir);
  assign x_ri = PW'(p_ri);
  assign x_dn_re = x_rr + x_ii;
  assign x_dn_im = x_ir - x_ri;
  assign x_c = PW'(p_bb_r) + PW'(p_bb_i);

  always_comb begin
    b_side = '0;
    b_side.eq = a_eq;
    b_n_re = '0;
    b_n_im = '0;
    b_c = '0;
    x_sum_re = '0;
    x_sum_im = '0;
    case (a_func)
      cau_pkg::FN_MUL: begin
        x_sum_re = x_rr - x_ii;
        x_sum_im = x_ir + x_ri;
      end
      cau_pkg::FN_NORM: begin
        x_sum_re = PW'(p_aa_r) + PW'(p_aa_i);
      end
      cau_pkg::FN_SCAL: begin
        x_sum_re = x_rr;
        x_sum_im = x_ir;
      end
      default: begin
      end
    endcase
    cr_re = from_prod(x_sum_re);
    cr_im = from_prod(x_sum_im);
    cv_re = clamp_v(a_s_re);
    cv_im = clamp_v(a_s_im);
    case (a_func)
      cau_pkg::FN_MUL, cau_pkg::FN_NORM, cau_pkg::FN_SCAL: begin
        b_side.sat = cr_re[W] | cr_im[W];
        b_side.re  = cr_re[W-1:0];
        b_side.im  = cr_im[W-1:0];
      end
      cau_pkg::FN_ADD, cau_pkg::FN_SUB, cau_pkg::FN_NEG, cau_pkg::FN_CONJ: begin
        b_side.sat = cv_re[W] | cv_im[W];
        b_side.re  = cv_re[W-1:0];
        b_side.im  = cv_im[W-1:0];
      end
      cau_pkg::FN_DIV: begin
        b_side.div    = 1'b1;
        b_side.dz     = (x_c == '0);
        b_side.neg_re = x_dn_re[PW-1];
        b_side.neg_im = x_dn_im[PW-1];
        b_n_re = MW'(x_dn_re[PW-1] ? PW'(-x_dn_re) : PW'(x_dn_re));
        b_n_im = MW'(x_dn_im[PW-1] ? PW'(-x_dn_im) : PW'(x_dn_im));
        b_c    = MW'(x_c);
      end
      cau_pkg::FN_RDIV: begin
        b_side.div    = 1'b1;
        b_side.dz     = a_brz;
        b_side.neg_re = a_neg_re;
        b_side.neg_im = a_neg_im;
        b_n_re = MW'(a_m_re);
        b_n_im = MW'(a_m_im);
        b_c    = MW'(a_m_br);
      end
      default: begin
      end
    endcase
  end

  logic [NS-1:0]   vld;
  side_t           sd [NS];
  logic [MW-1:0]   s_n_re, s_n_im;
  logic [RW-1:0]   rem_re [W+2];
  logic [RW-1:0]   rem_im [W+2];
  logic [RW-1:0]   dv [W+2];
  logic [QW-1:0]   q_re [W+2];
  logic [QW-1:0]   q_im [W+2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= a_vld;
    end
    if (en) begin
      sd[0]  <= b_side;
      s_n_re <= b_n_re;
      s_n_im <= b_n_im;
      dv[0]  <= RW'(b_c);
    end
  end

  // Stage C: numerators scaled by the fraction bits, check for a quotient out of range.
  logic [RW-1:0] c_num_re, c_num_im, c_lim;
  side_t         c_side;
  assign c_num_re = RW'(s_n_re) << F;
  assign c_num_im = RW'(s_n_im) << F;
  assign c_lim    = dv[0] << (W + 1);

  always_comb begin
    c_side = sd[0];
    c_side.ovf_re = (c_num_re >= c_lim);
    c_side.ovf_im = (c_num_im >= c_lim);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[1] <= 1'b0;
    end else if (en) begin
      vld[1] <= vld[0];
    end
    if (en) begin
      sd[1]     <= c_side;
      rem_re[0] <= c_num_re;
      rem_im[0] <= c_num_im;
      dv[1]     <= dv[0];
      q_re[0]   <= '0;
      q_im[0]   <= '0;
    end
  end

  // Restoring divider: one quotient bit per stage, most significant first.
  for (genvar j = 0; j <= W; j++) begin : g_div
    logic [RW-1:0] d;
    logic          ge_re, ge_im;
    assign d     = dv[j+1] << (W - j);
    assign ge_re = (rem_re[j] >= d);
    assign ge_im = (rem_im[j] >= d);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+2] <= 1'b0;
      end else if (en) begin
        vld[j+2] <= vld[j+1];
      end
      if (en) begin
        sd[j+2]       <= sd[j+1];
        rem_re[j+1]   <= ge_re ? rem_re[j] - d : rem_re[j];
        rem_im[j+1]   <= ge_im ? rem_im[j] - d : rem_im[j];
        q_re[j+1]     <= q_re[j] | (QW'(ge_re) << (W - j));
        q_im[j+1]     <= q_im[j] | (QW'(ge_im) << (W - j));
      end
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_dv
    always_ff @(posedge clk) begin
      if (en) begin
        dv[k+2] <= dv[k+1];
      end
    end
  end

  // Output register.
  side_t      f_side;
  logic [W:0] f_re, f_im;
  assign f_side = sd[NS-1];
  assign f_re = clamp_sm(f_side.neg_re, f_side.ovf_re ? '1 : PW'(q_re[W+1]));
  assign f_im = clamp_sm(f_side.neg_im, f_side.ovf_im ? '1 : PW'(q_im[W+1]));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[NS-1];
    end
    if (en) begin
      equal <= f_side.eq;
      if (f_side.div && f_side.dz) begin
        r_re   <= '0;
        r_im   <= '0;
        status <= cau_pkg::ST_DZ;
      end else if (f_side.div) begin
        r_re   <= f_re[W-1:0];
        r_im   <= f_im[W-1:0];
        status <= (f_re[W] | f_im[W]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end else begin
        r_re   <= f_side.re;
        r_im   <= f_side.im;
        status <= f_side.sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int DW = 16;
  localparam int FB = 8;
  localparam int FW = cau_pkg::FUNC_W;
  localparam int SW = cau_pkg::STAT_W;
  localparam longint MAXV = 32767;
  localparam longint MINV = -32768;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [FW-1:0] fn;
    logic signed [DW-1:0] ar;
    logic signed [DW-1:0] ai;
    logic signed [DW-1:0] br;
    logic signed [DW-1:0] bi;
  } operands_t;

  typedef struct packed {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    logic eq;
    logic [SW-1:0] st;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [FW-1:0] func = '0;
  logic signed [DW-1:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DW-1:0] r_re, r_im;
  logic equal;
  logic [SW-1:0] status;

  operands_t pending_ops[$];
  answer_t expected_answers[$];
  int errors = 0;
  int idle_cycles = 0;
  logic in_taken = 1'b0;
  int burst_left = 0, gap_left = 0;
  int stall_mode = 0, stall_left = 0;

  complex_arithmetic_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
    .out_valid(out_valid), .out_stall(out_stall),
    .r_re(r_re), .r_im(r_im), .equal(equal), .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp_sm(bit neg, longint unsigned mag, inout bit sat);
    if (!neg) begin
      if (mag > MAXV) begin
        sat = 1;
        return MAXV;
      end
      return longint'(mag);
    end
    if (mag > 64'd32768) begin
      sat = 1;
      return MINV;
    end
    return -longint'(mag);
  endfunction

  function automatic longint clamp_val(longint v, inout bit sat);
    if (v > MAXV) begin
      sat = 1;
      return MAXV;
    end
    if (v < MINV) begin
      sat = 1;
      return MINV;
    end
    return v;
  endfunction

  function automatic longint prod_to_data(longint v, inout bit sat);
    longint unsigned mag;
    mag = (v < 0) ? longint'(-v) : v;
    return clamp_sm(v < 0, mag >> FB, sat);
  endfunction

  function automatic longint unsigned frac_quot(longint unsigned n, longint unsigned c);
    return (n << FB) / c;
  endfunction

  function automatic answer_t compute_answer(operands_t op);
    answer_t res;
    longint ar, ai, br, bi, rr, ri, num;
    longint unsigned den;
    bit sat, dz;
    ar = op.ar; ai = op.ai; br = op.br; bi = op.bi;
    rr = 0; ri = 0; sat = 0; dz = 0;
    case (op.fn)
      cau_pkg::FN_ADD: begin
        rr = clamp_val(ar + br, sat);
        ri = clamp_val(ai + bi, sat);
      end
      cau_pkg::FN_SUB: begin
        rr = clamp_val(ar - br, sat);
        ri = clamp_val(ai - bi, sat);
      end
      cau_pkg::FN_MUL: begin
        rr = prod_to_data(ar * br - ai * bi, sat);
        ri = prod_to_data(ai * br + ar * bi, sat);
      end
      cau_pkg::FN_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          dz = 1;
        end else begin
          num = ar * br + ai * bi;
          rr = clamp_sm(num < 0, frac_quot((num < 0) ? -num : num, den), sat);
          num = ai * br - ar * bi;
          ri = clamp_sm(num < 0, frac_quot((num < 0) ? -num : num, den), sat);
        end
      end
      cau_pkg::FN_NEG: begin
        rr = clamp_val(-ar, sat);
        ri = clamp_val(-ai, sat);
      end
      cau_pkg::FN_NORM: rr = prod_to_data(ar * ar + ai * ai, sat);
      cau_pkg::FN_CONJ: begin
        rr = ar;
        ri = clamp_val(-ai, sat);
      end
      cau_pkg::FN_SCAL: begin
        rr = prod_to_data(ar * br, sat);
        ri = prod_to_data(ai * br, sat);
      end
      cau_pkg::FN_RDIV: begin
        if (br == 0) begin
          dz = 1;
        end else begin
          den = (br < 0) ? -br : br;
          rr = clamp_sm((ar < 0) != (br < 0), frac_quot((ar < 0) ? -ar : ar, den), sat);
          ri = clamp_sm((ai < 0) != (br < 0), frac_quot((ai < 0) ? -ai : ai, den), sat);
        end
      end
      default: ;
    endcase
    if (dz) begin
      rr = 0;
      ri = 0;
    end
    res.re = rr[DW-1:0];
    res.im = ri[DW-1:0];
    res.eq = (ar == br) && (ai == bi);
    res.st = dz ? cau_pkg::ST_DZ : (sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic signed [DW-1:0] rand_operand(int kind);
    case (kind)
      0: return DW'($urandom);
      1: return DW'($urandom_range(0, 2048)) - 16'sd1024;
      2: return DW'($urandom_range(0, 64)) - 16'sd32;
      default: begin
        case ($urandom_range(0, 4))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh0000;
          3: return 16'sh0100;
          default: return 16'shffff;
        endcase
      end
    endcase
  endfunction

  task automatic add_op(logic [FW-1:0] fn, logic signed [DW-1:0] ar, ai, br, bi);
    operands_t op;
    op.fn = fn; op.ar = ar; op.ai = ai; op.br = br; op.bi = bi;
    pending_ops.push_back(op);
  endtask

  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        operands_t op;
        op = pending_ops.pop_front();
        func <= op.fn; a_re <= op.ar; a_im <= op.ai; b_re <= op.br; b_im <= op.bi;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(5, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ~out_stall;
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall && !rst;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        operands_t op;
        op.fn = func; op.ar = a_re; op.ai = a_im; op.br = b_re; op.bi = b_im;
        expected_answers.push_back(compute_answer(op));
      end
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          $display("unexpected result transfer at %0t", $realtime);
          errors++;
        end else begin
          answer_t want;
          want = expected_answers.pop_front();
          if (r_re !== want.re) report_mismatch("r_re", r_re, want.re);
          if (r_im !== want.im) report_mismatch("r_im", r_im, want.im);
          if (equal !== want.eq) report_mismatch("equal", equal, want.eq);
          if (status !== want.st) report_mismatch("status", status, want.st);
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int kind;
    logic [FW-1:0] fn;
    logic signed [DW-1:0] ar, ai, br, bi;
    add_op(cau_pkg::FN_ADD, 16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff);
    add_op(cau_pkg::FN_SUB, 16'sh8000, 16'sh7fff, 16'sh0001, 16'shffff);
    add_op(cau_pkg::FN_MUL, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff);
    add_op(cau_pkg::FN_MUL, 16'sh0180, 16'shff40, 16'sh0080, 16'sh0033);
    add_op(cau_pkg::FN_DIV, 16'sh0100, 16'sh0200, 16'sh0000, 16'sh0000);
    add_op(cau_pkg::FN_DIV, 16'sh7fff, 16'sh8000, 16'sh0001, 16'sh0000);
    add_op(cau_pkg::FN_DIV, 16'sh0300, 16'shfe00, 16'sh0100, 16'sh0100);
    add_op(cau_pkg::FN_DIV, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    add_op(cau_pkg::FN_NEG, 16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0000);
    add_op(cau_pkg::FN_NORM, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000);
    add_op(cau_pkg::FN_NORM, 16'sh0003, 16'shfffc, 16'sh0000, 16'sh0000);
    add_op(cau_pkg::FN_CONJ, 16'sh1234, 16'sh8000, 16'sh1234, 16'sh8000);
    add_op(cau_pkg::FN_CONJ, 16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0000);
    add_op(cau_pkg::FN_SCAL, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh1111);
    add_op(cau_pkg::FN_SCAL, 16'shff01, 16'sh00ff, 16'sh0080, 16'sh0000);
    add_op(cau_pkg::FN_RDIV, 16'sh0100, 16'sh0100, 16'sh0000, 16'sh7fff);
    add_op(cau_pkg::FN_RDIV, 16'sh8000, 16'sh7fff, 16'shffff, 16'sh0000);
    add_op(cau_pkg::FN_RDIV, 16'shfffd, 16'sh0005, 16'sh0300, 16'sh0000);
    add_op(4'd9, 16'sh0005, 16'sh0006, 16'sh0005, 16'sh0006);
    add_op(4'd15, 16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0000);
    add_op(cau_pkg::FN_ADD, 16'shffff, 16'shffff, 16'shffff, 16'shffff);
    repeat (900) begin
      fn = ($urandom_range(0, 19) == 0) ? FW'($urandom_range(9, 15))
                                        : FW'($urandom_range(0, 8));
      kind = $urandom_range(0, 3);
      ar = rand_operand(kind);
      ai = rand_operand(kind);
      case ($urandom_range(0, 9))
        0: begin br = ar; bi = ai; end
        1: begin br = '0; bi = ($urandom_range(0, 1) == 1) ? 16'sh0000 : rand_operand(kind); end
        default: begin br = rand_operand($urandom_range(0, 3)); bi = rand_operand(kind); end
      endcase
      add_op(fn, ar, ai, br, bi);
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (!(pending_ops.size() == 0 && !in_valid && expected_answers.size() == 0)) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
design/cau_pkg.sv
design/complex_arithmetic_unit.sv
tb/testbench.sv
